>>> rtl/nearest_neighbour_link_builder_top_defines.svh
// Assertion macros for the nearest-neighbour link builder.
// Used by nearest_neighbour_link_builder_top.sv; expects signals clk and rst in scope.
`ifndef NEAREST_NEIGHBOUR_LINK_BUILDER_TOP_DEFINES_SVH
`define NEAREST_NEIGHBOUR_LINK_BUILDER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NNLB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NNLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nnlb_pkg.sv
// Shared constants and types for the nearest-neighbour link builder.
// No dependencies; used by nearest_neighbour_link_builder_top.
`timescale 1ns / 1ps

package nnlb_pkg;

  localparam int POINTS     = 2048;
  localparam int IDX_W      = $clog2(POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_BITS = 16;
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUM_W      = SQ_W + 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_LINK = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SRC    = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

>>> rtl/nnlb_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nnlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/nearest_neighbour_link_builder_top.sv
// Top level of the nearest-neighbour link builder.
// Depends on nnlb_pkg, nnlb_ram and nearest_neighbour_link_builder_top_defines.svh.
`timescale 1ns / 1ps
`include "nearest_neighbour_link_builder_top_defines.svh"

// Usage
// A command transaction is taken on a rising edge with start high and busy low.
// A load command (cmd low) writes the three coordinates into the point memory
// in that same cycle and produces no result; busy stays low, so another command
// may follow in the very next cycle.
// A link command (cmd high) raises busy and streams every point below
// points_in_use (saturated to the store size) out of the point memory, one
// candidate per clock through its single read port, alongside the matching
// partner entry. The squared distance runs through a two-stage pipeline
// (squares, then sum and compare). A link fetches the source point, then scans
// limit candidates, limit being the saturated points_in_use (2048 after reset),
// then drains; with a limit of zero nothing enters the pipeline.
// The result transaction is shown for exactly one cycle with done high, in the
// last busy cycle; the receiver cannot stall it and must take it there.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) is always ready
// and should only be written while busy is low.
// After reset the partner memory is cleared one entry a cycle, so busy stays
// high until every entry is cleared, before the first command can be taken;
// configuration writes are still taken during this pass.

module nearest_neighbour_link_builder_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             cmd,
  input  logic [nnlb_pkg::IDX_W-1:0]       point_index,
  input  logic signed [nnlb_pkg::COORD_BITS-1:0] coord_x,
  input  logic signed [nnlb_pkg::COORD_BITS-1:0] coord_y,
  input  logic signed [nnlb_pkg::COORD_BITS-1:0] coord_z,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [nnlb_pkg::CNT_W-1:0]       cfg_data,
  output logic                             done,
  output logic [nnlb_pkg::IDX_W-1:0]       source_index,
  output logic [nnlb_pkg::IDX_W-1:0]       partner_index,
  output logic                             found_flag
);

  localparam int CW = nnlb_pkg::COORD_BITS;

  nnlb_pkg::state_t state;
  nnlb_pkg::cnt_t   points_in_use;
  nnlb_pkg::cnt_t   scan_lim;
  nnlb_pkg::cnt_t   scan_j;
  nnlb_pkg::idx_t   clr_cnt;
  nnlb_pkg::idx_t   src_idx;
  nnlb_pkg::idx_t   best_idx;
  logic [nnlb_pkg::SUM_W-1:0] best_dist;
  logic             found;

  // Source point captured in the first scan cycle.
  logic             src_cap;
  nnlb_pkg::coord_t src_x, src_y, src_z;

  // Point memory ports.
  logic                       pt_we;
  logic [nnlb_pkg::PT_W-1:0]  pt_wdata;
  nnlb_pkg::idx_t             pt_raddr;
  logic [nnlb_pkg::PT_W-1:0]  pt_rdata;

  // Partner memory ports.
  logic           pr_we;
  nnlb_pkg::idx_t pr_waddr;
  nnlb_pkg::idx_t pr_wdata;
  nnlb_pkg::idx_t pr_rdata;

  // Pipeline stage 1: memory data is valid.
  logic           s1_valid;
  nnlb_pkg::idx_t s1_j;
  // Pipeline stage 2: squared components registered.
  logic           s2_valid;
  logic           s2_adm;
  nnlb_pkg::idx_t s2_j;
  logic [nnlb_pkg::SQ_W-1:0] sq_x, sq_y, sq_z;

  logic accept;
  logic issue;
  nnlb_pkg::coord_t q_x, q_y, q_z;
  logic signed [nnlb_pkg::DIFF_W-1:0] dx, dy, dz;
  logic [CW-1:0] mx, my, mz;
  logic [nnlb_pkg::SUM_W-1:0] cand_dist;
  logic better;

  assign cfg_ready = 1'b1;
  assign busy      = (state != nnlb_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign issue     = (state == nnlb_pkg::ST_SCAN) && (scan_j != scan_lim);

  // Point memory: loads write straight away; reads serve the source fetch and the scan.
  assign pt_we    = accept && (cmd == nnlb_pkg::CMD_LOAD);
  assign pt_wdata = {coord_z, coord_y, coord_x};
  assign pt_raddr = (state == nnlb_pkg::ST_SCAN) ? scan_j[nnlb_pkg::IDX_W-1:0] : src_idx;

  nnlb_ram #(
    .WIDTH (nnlb_pkg::PT_W),
    .DEPTH (nnlb_pkg::POINTS)
  ) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (point_index),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // Partner memory: cleared after reset, written once at the end of each link.
  assign pr_we    = (state == nnlb_pkg::ST_CLEAR) || (state == nnlb_pkg::ST_FINISH);
  assign pr_waddr = (state == nnlb_pkg::ST_CLEAR) ? clr_cnt : src_idx;
  assign pr_wdata = (state == nnlb_pkg::ST_CLEAR) ? '0 : best_idx;

  nnlb_ram #(
    .WIDTH (nnlb_pkg::IDX_W),
    .DEPTH (nnlb_pkg::POINTS)
  ) u_partner_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_waddr),
    .wdata (pr_wdata),
    .raddr (scan_j[nnlb_pkg::IDX_W-1:0]),
    .rdata (pr_rdata)
  );

  // Stage 1 arithmetic: absolute component differences and their squares.
  always_comb begin
    q_x = pt_rdata[CW-1:0];
    q_y = pt_rdata[2*CW-1:CW];
    q_z = pt_rdata[3*CW-1:2*CW];
    dx  = nnlb_pkg::DIFF_W'(src_x) - nnlb_pkg::DIFF_W'(q_x);
    dy  = nnlb_pkg::DIFF_W'(src_y) - nnlb_pkg::DIFF_W'(q_y);
    dz  = nnlb_pkg::DIFF_W'(src_z) - nnlb_pkg::DIFF_W'(q_z);
    mx  = dx[nnlb_pkg::DIFF_W-1] ? CW'(-dx) : CW'(dx);
    my  = dy[nnlb_pkg::DIFF_W-1] ? CW'(-dy) : CW'(dy);
    mz  = dz[nnlb_pkg::DIFF_W-1] ? CW'(-dz) : CW'(dz);
  end

  // Stage 2 arithmetic: sum and strict compare, so the lowest index wins a tie.
  assign cand_dist = nnlb_pkg::SUM_W'(sq_x) + nnlb_pkg::SUM_W'(sq_y) +
                     nnlb_pkg::SUM_W'(sq_z);
  assign better    = s2_valid && s2_adm && (!found || (cand_dist < best_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nnlb_pkg::ST_CLEAR;
      clr_cnt       <= '0;
      points_in_use <= nnlb_pkg::CNT_W'(nnlb_pkg::POINTS);
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      src_cap       <= 1'b0;
      found         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        points_in_use <= cfg_data;
      end

      src_cap  <= (state == nnlb_pkg::ST_SRC);
      s1_valid <= issue;
      s2_valid <= s1_valid;

      if (better) begin
        found <= 1'b1;
      end

      unique case (state)
        nnlb_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= nnlb_pkg::ST_IDLE;
          end
        end
        nnlb_pkg::ST_IDLE: begin
          if (accept && (cmd == nnlb_pkg::CMD_LINK)) begin
            found <= 1'b0;
            state <= nnlb_pkg::ST_SRC;
          end
        end
        nnlb_pkg::ST_SRC: begin
          state <= nnlb_pkg::ST_SCAN;
        end
        nnlb_pkg::ST_SCAN: begin
          if (!issue) begin
            state <= nnlb_pkg::ST_DRAIN;
          end
        end
        nnlb_pkg::ST_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            state <= nnlb_pkg::ST_FINISH;
          end
        end
        nnlb_pkg::ST_FINISH: begin
          state <= nnlb_pkg::ST_IDLE;
        end
        default: begin
          state <= nnlb_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      src_idx  <= point_index;
      scan_j   <= '0;
      best_idx <= '0;
      scan_lim <= (points_in_use > nnlb_pkg::CNT_W'(nnlb_pkg::POINTS)) ?
                  nnlb_pkg::CNT_W'(nnlb_pkg::POINTS) : points_in_use;
    end else if (issue) begin
      scan_j <= scan_j + 1'b1;
    end

    if (src_cap) begin
      src_x <= pt_rdata[CW-1:0];
      src_y <= pt_rdata[2*CW-1:CW];
      src_z <= pt_rdata[3*CW-1:2*CW];
    end

    s1_j   <= scan_j[nnlb_pkg::IDX_W-1:0];
    s2_j   <= s1_j;
    s2_adm <= (s1_j != src_idx) && (pr_rdata != src_idx);
    sq_x   <= nnlb_pkg::SQ_W'(mx) * nnlb_pkg::SQ_W'(mx);
    sq_y   <= nnlb_pkg::SQ_W'(my) * nnlb_pkg::SQ_W'(my);
    sq_z   <= nnlb_pkg::SQ_W'(mz) * nnlb_pkg::SQ_W'(mz);

    if (better) begin
      best_dist <= cand_dist;
      best_idx  <= s2_j;
    end
  end

  assign done          = (state == nnlb_pkg::ST_FINISH);
  assign source_index  = src_idx;
  assign partner_index = best_idx;
  assign found_flag    = found;

  // The result is only shown once every candidate has left the pipeline.
  `NNLB_ASSERT_SAME(a_done_drained, done, !s1_valid && !s2_valid, "result before pipeline drained")
  // A link with no admissible candidate reports partner zero.
  `NNLB_ASSERT_SAME(a_none_is_zero, done && !found_flag, partner_index == '0, "no partner but index set")
  // The block is ready for a new command right after a result.
  `NNLB_ASSERT_NEXT(a_idle_after_done, done, !busy, "busy after result")
  // Loads never land while a scan or the clearing pass is running.
  `NNLB_ASSERT_SAME(a_load_when_idle, pt_we, state == nnlb_pkg::ST_IDLE, "point write while busy")

endmodule
